// File: sv/vrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types and constants of the video register port: request and result
// payloads, mode and register codes, memory sizes, controller/datapath link.
// ----------------------------------------------------------------------------
package vrp_pkg;

    // memory sizes
    localparam int NT_BYTES    = 1024;
    localparam int NT_DEPTH    = 2 * NT_BYTES;
    localparam int SPR_BYTES   = 256;
    localparam int PAT_BYTES   = 8192;
    localparam int PAL_ENTRIES = 32;
    localparam int NT_AW       = $clog2(NT_DEPTH);
    localparam int SPR_AW      = $clog2(SPR_BYTES);
    localparam int PAT_AW      = $clog2(PAT_BYTES);
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);

    // request modes
    localparam logic [2:0] MODE_CPU_READ        = 3'd0;
    localparam logic [2:0] MODE_CPU_WRITE       = 3'd1;
    localparam logic [2:0] MODE_VBLANK_START    = 3'd2;
    localparam logic [2:0] MODE_PRERENDER_CLEAR = 3'd3;
    localparam logic [2:0] MODE_RENDER_FLAGS    = 3'd4;

    // cpu register numbers
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // request payload
    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic       zero_hit_seen;
        logic       overflow_seen;
    } t_in_item;

    // result payload
    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi_request;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic finish;
        logic clear;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
    } t_dp_stat;

endpackage

// File: sv/video_register_port_with_vram_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_register_port_with_vram_map
// CPU register port of a tile video chip with its video address decoder.
// ----------------------------------------------------------------------------
// Usage
//   Request channel i_in_valid / o_in_stall / i_in_data carries cpu reads,
//   cpu writes and frame events (vblank start, prerender clear, render flags).
//   Result channel o_out_valid / i_out_stall / o_out_data returns one result
//   per request: the read byte (zero for non-reads) and the nmi request.
//   Mirroring is set through i_cfg_wr_en / i_cfg_wr_data while idle.
// Timing
//   A request is taken in ST_IDLE and its result is written to the output
//   register from ST_RESP once that register is free; the next request is
//   taken only after that. The limit is the registered read of the RAMs.
//   o_out_valid rises once the result is in the output register.
// Reset
//   After reset all 2048 nametable entries are swept to zero, one entry per
//   cycle, with o_in_stall high; mirroring writes still apply.
// Stall
//   A held result stays in the output register; the following request is
//   still taken and waits with its result until the register frees up.
// ----------------------------------------------------------------------------
module video_register_port_with_vram_map
    import vrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    vrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // registers, decoder and memories
    vrp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_data    (o_out_data)
    );

endmodule

// File: sv/vrp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module vrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/vrp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_ctrl
// Sequencer of the register port: nametable clearing after reset, request
// intake, result delivery into the output register.
// ----------------------------------------------------------------------------
module vrp_ctrl
    import vrp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESP
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_finish;

    // handshake decode
    assign w_accept = (r_state == ST_IDLE) && i_in_valid;
    assign w_finish = (r_state == ST_RESP) && (!r_out_valid || !i_out_stall);

    assign o_cmd.accept = w_accept;
    assign o_cmd.finish = w_finish;
    assign o_cmd.clear  = (r_state == ST_CLEAR);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    if (i_stat.clear_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (w_finish) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    // an accepted request always moves on to its result cycle
    a_accept_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_RESP))
        else $error("accepted request did not reach result state");

    // a finished request leaves a valid result behind
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> r_out_valid)
        else $error("finished request produced no result");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while one is in flight");

    // no result can exist during the clearing pass
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_valid)
        else $error("result valid during clearing pass");
`endif

endmodule

// File: sv/vrp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_dp
// Datapath of the register port: cpu registers, scroll/address latches,
// video address decode, sprite/pattern/nametable RAMs, palette and result.
// ----------------------------------------------------------------------------
module vrp_dp
    import vrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  t_in_item  i_in_data,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    output t_out_item o_out_data
);

    typedef enum logic [2:0] {
        SRC_DIRECT,
        SRC_SPRITE,
        SRC_PATTERN,
        SRC_NAMETABLE,
        SRC_PALETTE
    } t_rd_src;

    logic              r_mirror_v;
    logic [7:0]        r_ctrl;
    logic [7:0]        r_mask;
    logic [2:0]        r_flags;
    logic              r_toggle;
    logic [14:0]       r_tmp;
    logic [14:0]       r_vaddr;
    logic [7:0]        r_rbuf;
    logic [SPR_AW-1:0] r_spr_addr;
    logic [5:0]        r_pal [PAL_ENTRIES];
    logic [NT_AW-1:0]  r_clr_addr;
    t_rd_src           r_src;
    logic [7:0]        r_rd;
    logic [5:0]        r_pal_rd;
    logic              r_nmi;
    t_out_item         r_out;

    logic              w_is_rd;
    logic              w_is_wr;
    logic              w_is_pat;
    logic              w_is_pal;
    logic              w_is_nt;
    logic [NT_AW-1:0]  w_nt_idx;
    logic [PAL_AW-1:0] w_pal_idx;
    logic [5:0]        w_pal_mask;
    logic              w_data_rd;
    logic              w_data_wr;
    logic [14:0]       w_vaddr_inc;
    logic [14:0]       n_tmp;
    t_rd_src           n_src;
    logic [7:0]        n_rd;
    logic [2:0]        n_flags;
    logic [7:0]        w_spr_q;
    logic [7:0]        w_pat_q;
    logic [7:0]        w_nt_q;
    logic [7:0]        w_vram_q;
    logic [7:0]        w_rd;

    // request decode
    assign w_is_rd   = (i_in_data.mode == MODE_CPU_READ);
    assign w_is_wr   = (i_in_data.mode == MODE_CPU_WRITE);
    assign w_data_rd = i_cmd.accept && w_is_rd && (i_in_data.reg_index == REG_DATA);
    assign w_data_wr = i_cmd.accept && w_is_wr && (i_in_data.reg_index == REG_DATA);

    // video address decode on the low 14 bits
    assign w_is_pat   = !r_vaddr[13];
    assign w_is_pal   = (r_vaddr[13:8] == 6'h3F);
    assign w_is_nt    = !w_is_pat && !w_is_pal;
    assign w_nt_idx   = {(r_mirror_v ? r_vaddr[10] : r_vaddr[11]), r_vaddr[9:0]};
    assign w_pal_idx  = {r_vaddr[4] && (r_vaddr[1:0] != 2'b00), r_vaddr[3:0]};
    assign w_pal_mask = r_mask[0] ? 6'h30 : 6'h3F;

    // address step of 1 or 32, wrapping at 15 bits
    assign w_vaddr_inc = r_vaddr + (r_ctrl[2] ? 15'd32 : 15'd1);

    // next temporary address, status flags and read source
    always_comb begin
        n_tmp   = r_tmp;
        n_flags = r_flags;
        n_src   = SRC_DIRECT;
        n_rd    = 8'h00;
        unique case (i_in_data.mode)
            MODE_CPU_READ: begin
                if (i_in_data.reg_index == REG_STATUS) begin
                    n_rd    = {r_flags, r_rbuf[4:0]};
                    n_flags = {1'b0, r_flags[1:0]};
                end else if (i_in_data.reg_index == REG_OAM_DATA) begin
                    n_src = SRC_SPRITE;
                end else if (i_in_data.reg_index == REG_DATA) begin
                    n_rd = r_rbuf;
                    if (w_is_pat) begin
                        n_src = SRC_PATTERN;
                    end else if (w_is_nt) begin
                        n_src = SRC_NAMETABLE;
                    end else begin
                        n_src = SRC_PALETTE;
                    end
                end
            end
            MODE_CPU_WRITE: begin
                if (i_in_data.reg_index == REG_CTRL) begin
                    n_tmp[11:10] = i_in_data.write_data[1:0];
                end else if (i_in_data.reg_index == REG_SCROLL) begin
                    if (!r_toggle) begin
                        n_tmp[4:0] = i_in_data.write_data[7:3];
                    end else begin
                        n_tmp[14:12] = i_in_data.write_data[2:0];
                        n_tmp[9:5]   = i_in_data.write_data[7:3];
                    end
                end else if (i_in_data.reg_index == REG_ADDR) begin
                    if (!r_toggle) begin
                        n_tmp[14:8] = {1'b0, i_in_data.write_data[5:0]};
                    end else begin
                        n_tmp[7:0] = i_in_data.write_data;
                    end
                end
            end
            MODE_VBLANK_START: begin
                n_flags = r_flags | 3'b100;
            end
            MODE_PRERENDER_CLEAR: begin
                n_flags = 3'b000;
            end
            MODE_RENDER_FLAGS: begin
                n_flags = {r_flags[2], r_flags[1] | i_in_data.zero_hit_seen,
                           i_in_data.overflow_seen};
            end
            default: begin
                n_flags = r_flags;
            end
        endcase
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror_v <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mirror_v <= i_cfg_wr_data;
        end
    end

    // cpu visible state, updated when a request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl     <= 8'h00;
            r_mask     <= 8'h00;
            r_flags    <= 3'b000;
            r_toggle   <= 1'b0;
            r_tmp      <= 15'h0000;
            r_vaddr    <= 15'h0000;
            r_spr_addr <= '0;
        end else if (i_cmd.accept) begin
            r_tmp   <= n_tmp;
            r_flags <= n_flags;
            if (w_data_rd || w_data_wr) begin
                r_vaddr <= w_vaddr_inc;
            end
            if (w_is_rd && (i_in_data.reg_index == REG_STATUS)) begin
                r_toggle <= 1'b0;
            end
            if (w_is_wr) begin
                unique case (i_in_data.reg_index)
                    REG_CTRL:     r_ctrl <= i_in_data.write_data;
                    REG_MASK:     r_mask <= i_in_data.write_data;
                    REG_OAM_ADDR: r_spr_addr <= i_in_data.write_data;
                    REG_OAM_DATA: r_spr_addr <= r_spr_addr + 1'b1;
                    REG_SCROLL:   r_toggle <= !r_toggle;
                    REG_ADDR: begin
                        r_toggle <= !r_toggle;
                        if (r_toggle) begin
                            r_vaddr <= n_tmp;
                        end
                    end
                    default: begin
                        r_toggle <= r_toggle;
                    end
                endcase
            end
        end
    end

    // palette entries, six bits each
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAL_ENTRIES; i++) begin
                r_pal[i] <= 6'h00;
            end
        end else if (w_data_wr && w_is_pal) begin
            r_pal[w_pal_idx] <= i_in_data.write_data[5:0];
        end
    end

    // per-request result context
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_src    <= n_src;
            r_rd     <= n_rd;
            r_pal_rd <= r_pal[w_pal_idx] & w_pal_mask;
            r_nmi    <= (i_in_data.mode == MODE_VBLANK_START) && r_ctrl[7];
        end
    end

    // nametable clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_stat.clear_last = (r_clr_addr == {NT_AW{1'b1}});

    // sprite attribute memory
    vrp_ram #(
        .WIDTH (8),
        .DEPTH (SPR_BYTES)
    ) u_spr_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && w_is_wr && (i_in_data.reg_index == REG_OAM_DATA)),
        .i_re    (i_cmd.accept && w_is_rd && (i_in_data.reg_index == REG_OAM_DATA)),
        .i_addr  (r_spr_addr),
        .i_wdata (i_in_data.write_data),
        .o_rdata (w_spr_q)
    );

    // pattern memory
    vrp_ram #(
        .WIDTH (8),
        .DEPTH (PAT_BYTES)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (w_data_wr && w_is_pat),
        .i_re    (w_data_rd && w_is_pat),
        .i_addr  (r_vaddr[PAT_AW-1:0]),
        .i_wdata (i_in_data.write_data),
        .o_rdata (w_pat_q)
    );

    // nametable memory, zeroed by the clearing pass
    vrp_ram #(
        .WIDTH (8),
        .DEPTH (NT_DEPTH)
    ) u_nt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clear || (w_data_wr && w_is_nt)),
        .i_re    (w_data_rd && w_is_nt),
        .i_addr  (i_cmd.clear ? r_clr_addr : w_nt_idx),
        .i_wdata (i_cmd.clear ? 8'h00 : i_in_data.write_data),
        .o_rdata (w_nt_q)
    );

    // result select
    always_comb begin
        w_vram_q = {2'b00, r_pal_rd};
        w_rd     = r_rd;
        unique case (r_src)
            SRC_DIRECT:    w_rd = r_rd;
            SRC_SPRITE:    w_rd = w_spr_q;
            SRC_PATTERN:   w_vram_q = w_pat_q;
            SRC_NAMETABLE: w_vram_q = w_nt_q;
            SRC_PALETTE:   w_rd = {2'b00, r_pal_rd};
            default:       w_rd = r_rd;
        endcase
    end

    // read buffer refill on data port reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rbuf <= 8'h00;
        end else if (i_cmd.finish &&
                     (r_src == SRC_PATTERN || r_src == SRC_NAMETABLE ||
                      r_src == SRC_PALETTE)) begin
            r_rbuf <= w_vram_q;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.read_data   <= w_rd;
            r_out.nmi_request <= r_nmi;
        end
    end

    assign o_out_data = r_out;

endmodule

// File: tb/sv/vrp_port_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_port_checker
// Watches the request, result and mirroring ports of the video register port.
// Keeps its own registers and video memories, works out the result of every
// accepted request and compares the returned results with them in order.
// ----------------------------------------------------------------------------
module vrp_port_checker
    import vrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    output int        o_errors,
    output int        o_pending
);

    // register copies
    logic        mirror_v;
    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic [2:0]  flags_q;     // vblank, sprite zero hit, overflow
    logic        toggle_q;
    logic [2:0]  fine_x_q;
    logic [14:0] tmp_addr_q;
    logic [14:0] vid_addr_q;
    logic [7:0]  rbuf_q;
    logic [7:0]  oam_addr_q;

    // memory copies
    logic [7:0]  oam_mem [SPR_BYTES];
    logic [7:0]  nt_mem  [NT_DEPTH];
    logic [5:0]  pal_mem [PAL_ENTRIES];
    logic [7:0]  pat_mem [PAT_BYTES];

    t_out_item   port_replies [$];
    int          mismatches = 0;

    // nametable entry behind a video address
    function automatic logic [NT_AW-1:0] nt_slot(input logic [13:0] a);
        return {(mirror_v ? a[10] : a[11]), a[9:0]};
    endfunction

    // palette entry, backdrop copies at 0x10/14/18/1c fold onto 0x00/04/08/0c
    function automatic logic [PAL_AW-1:0] pal_slot(input logic [13:0] a);
        logic [4:0] p;
        p = a[4:0];
        if (p[4] && p[1:0] == 2'b00) p[4] = 1'b0;
        return p;
    endfunction

    // applies one request to the copies and returns its result
    task automatic port_apply(input t_in_item rq, output t_out_item res);
        logic [13:0] a;
        logic [7:0]  d;
        a   = vid_addr_q[13:0];
        d   = rq.write_data;
        res = '0;
        case (rq.mode)
            MODE_CPU_READ: begin
                case (rq.reg_index)
                    REG_STATUS: begin
                        res.read_data = {flags_q, rbuf_q[4:0]};
                        flags_q[2] = 1'b0;
                        toggle_q   = 1'b0;
                    end
                    REG_OAM_DATA: res.read_data = oam_mem[oam_addr_q];
                    REG_DATA: begin
                        res.read_data = rbuf_q;
                        if (a < 14'h2000) begin
                            rbuf_q = pat_mem[a[12:0]];
                        end else if (a < 14'h3F00) begin
                            rbuf_q = nt_mem[nt_slot(a)];
                        end else begin
                            // palette skips the buffer delay, grayscale keeps 0x30
                            rbuf_q = {2'b00, pal_mem[pal_slot(a)]} & (mask_q[0] ? 8'h30 : 8'h3F);
                            res.read_data = rbuf_q;
                        end
                        vid_addr_q = vid_addr_q + (ctrl_q[2] ? 15'd32 : 15'd1);
                    end
                    default: ;
                endcase
            end
            MODE_CPU_WRITE: begin
                case (rq.reg_index)
                    REG_CTRL: begin
                        ctrl_q            = d;
                        tmp_addr_q[11:10] = d[1:0];
                    end
                    REG_MASK:     mask_q = d;
                    REG_OAM_ADDR: oam_addr_q = d;
                    REG_OAM_DATA: begin
                        oam_mem[oam_addr_q] = d;
                        oam_addr_q          = oam_addr_q + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!toggle_q) begin
                            fine_x_q        = d[2:0];
                            tmp_addr_q[4:0] = d[7:3];
                        end else begin
                            tmp_addr_q = {d[2:0], tmp_addr_q[11:10], d[7:3], tmp_addr_q[4:0]};
                        end
                        toggle_q = !toggle_q;
                    end
                    REG_ADDR: begin
                        if (!toggle_q) begin
                            tmp_addr_q = {1'b0, d[5:0], tmp_addr_q[7:0]};
                        end else begin
                            tmp_addr_q[7:0] = d;
                            vid_addr_q      = tmp_addr_q;
                        end
                        toggle_q = !toggle_q;
                    end
                    REG_DATA: begin
                        if (a < 14'h2000) pat_mem[a[12:0]] = d;
                        else if (a < 14'h3F00) nt_mem[nt_slot(a)] = d;
                        else pal_mem[pal_slot(a)] = d[5:0];
                        vid_addr_q = vid_addr_q + (ctrl_q[2] ? 15'd32 : 15'd1);
                    end
                    default: ;
                endcase
            end
            MODE_VBLANK_START: begin
                flags_q[2]      = 1'b1;
                res.nmi_request = ctrl_q[7];
            end
            MODE_PRERENDER_CLEAR: flags_q = 3'b000;
            MODE_RENDER_FLAGS: begin
                if (rq.zero_hit_seen) flags_q[1] = 1'b1;
                flags_q[0] = rq.overflow_seen;
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    // watch both channels and the mirroring port
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            mirror_v   = 1'b0;
            ctrl_q     = '0;
            mask_q     = '0;
            flags_q    = '0;
            toggle_q   = 1'b0;
            fine_x_q   = '0;
            tmp_addr_q = '0;
            vid_addr_q = '0;
            rbuf_q     = '0;
            oam_addr_q = '0;
            for (int i = 0; i < SPR_BYTES; i++) oam_mem[i] = '0;
            for (int i = 0; i < NT_DEPTH; i++) nt_mem[i] = '0;
            for (int i = 0; i < PAL_ENTRIES; i++) pal_mem[i] = '0;
            for (int i = 0; i < PAT_BYTES; i++) pat_mem[i] = '0;
            port_replies.delete();
        end else begin
            if (i_cfg_wr_en) mirror_v = i_cfg_wr_data;
            // returned result against the oldest outstanding one
            if (i_out_valid && !i_out_stall) begin
                if (port_replies.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result with no request outstanding, expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    want = port_replies.pop_front();
                    if (i_out_data.read_data !== want.read_data)
                        note_mismatch("read_data", want.read_data, i_out_data.read_data);
                    if (i_out_data.nmi_request !== want.nmi_request)
                        note_mismatch("nmi_request", want.nmi_request, i_out_data.nmi_request);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                port_apply(i_in_data, want);
                port_replies.push_back(want);
            end
        end
        o_errors  <= mismatches;
        o_pending <= port_replies.size();
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the video register port: a directed pass over the registers
// and frame events, then random register sequences under both mirroring
// settings, with random idling, a long result hold-off and a stretch with no
// idling. Results are judged by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb;
    import vrp_pkg::*;

    localparam int         DEAD_LIMIT     = 8000;
    localparam int         RANDOM_ITEMS   = 950;
    localparam int         PHASES         = 4;
    localparam int         HOLD_CYCLES    = 400;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      in_valid    = 1'b0;
    logic      in_stall;
    t_in_item  in_data     = '0;
    logic      out_valid;
    logic      out_stall   = 1'b0;
    t_out_item out_data;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    int        errors;
    int        pending;

    int        dead_cycles  = 0;
    int        hold_left    = 0;
    int        items_sent   = 0;
    logic      quiet        = 1'b0;   // no idling on either side
    logic      squeeze_go   = 1'b0;
    logic      squeeze_done = 1'b0;

    // address state seen by the stimulus, keeps reads on written entries
    logic        trk_inc32    = 1'b0;
    logic        trk_toggle   = 1'b0;
    logic [14:0] trk_tmp      = '0;
    logic [14:0] trk_vaddr    = '0;
    logic [7:0]  trk_oam_addr = '0;
    bit          oam_written [SPR_BYTES];
    bit          pat_written [PAT_BYTES];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    video_register_port_with_vram_map dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    vrp_port_checker port_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    // result side: random stalls, one long hold-off, none while quiet
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (squeeze_go && !squeeze_done) begin
            out_stall    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            squeeze_done <= 1'b1;
        end else begin
            out_stall <= !quiet && ($urandom_range(0, 99) < 37);
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            dead_cycles <= 0;
        end else if (dead_cycles >= DEAD_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            dead_cycles <= dead_cycles + 1;
        end
    end

    function automatic t_in_item make_req(input logic [2:0] m, input logic [2:0] r,
                                          input logic [7:0] d);
        t_in_item rq;
        rq.mode          = m;
        rq.reg_index     = r;
        rq.write_data    = d;
        rq.zero_hit_seen = 1'($urandom_range(0, 1));
        rq.overflow_seen = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    // turn reads of never-written sprite or pattern bytes into writes, then track
    task automatic track_request(inout t_in_item rq);
        logic [13:0] a;
        logic [7:0]  d;
        a = trk_vaddr[13:0];
        d = rq.write_data;
        if (rq.mode == MODE_CPU_READ && rq.reg_index == REG_OAM_DATA
            && !oam_written[trk_oam_addr])
            rq.mode = MODE_CPU_WRITE;
        if (rq.mode == MODE_CPU_READ && rq.reg_index == REG_DATA
            && a < 14'h2000 && !pat_written[a[12:0]])
            rq.mode = MODE_CPU_WRITE;
        if (rq.mode == MODE_CPU_READ) begin
            if (rq.reg_index == REG_STATUS) trk_toggle = 1'b0;
            if (rq.reg_index == REG_DATA) trk_vaddr = trk_vaddr + (trk_inc32 ? 15'd32 : 15'd1);
        end else if (rq.mode == MODE_CPU_WRITE) begin
            case (rq.reg_index)
                REG_CTRL: begin
                    trk_inc32      = d[2];
                    trk_tmp[11:10] = d[1:0];
                end
                REG_OAM_ADDR: trk_oam_addr = d;
                REG_OAM_DATA: begin
                    oam_written[trk_oam_addr] = 1'b1;
                    trk_oam_addr              = trk_oam_addr + 8'd1;
                end
                REG_SCROLL: begin
                    if (!trk_toggle) trk_tmp[4:0] = d[7:3];
                    else trk_tmp = {d[2:0], trk_tmp[11:10], d[7:3], trk_tmp[4:0]};
                    trk_toggle = !trk_toggle;
                end
                REG_ADDR: begin
                    if (!trk_toggle) begin
                        trk_tmp = {1'b0, d[5:0], trk_tmp[7:0]};
                    end else begin
                        trk_tmp[7:0] = d;
                        trk_vaddr    = trk_tmp;
                    end
                    trk_toggle = !trk_toggle;
                end
                REG_DATA: begin
                    if (a < 14'h2000) pat_written[a[12:0]] = 1'b1;
                    trk_vaddr = trk_vaddr + (trk_inc32 ? 15'd32 : 15'd1);
                end
                default: ;
            endcase
        end
    endtask

    // offer one request, with random idle cycles ahead of it
    task automatic push_req(input t_in_item rq);
        track_request(rq);
        while (!quiet && $urandom_range(0, 99) < 37) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rq;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic wr(input logic [2:0] r, input logic [7:0] d);
        push_req(make_req(MODE_CPU_WRITE, r, d));
    endtask

    task automatic rd(input logic [2:0] r);
        push_req(make_req(MODE_CPU_READ, r, 8'($urandom_range(0, 255))));
    endtask

    task automatic frame_event(input logic [2:0] m);
        push_req(make_req(m, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
    endtask

    task automatic render_flags(input logic zero_hit, input logic overflow);
        t_in_item rq;
        rq               = make_req(MODE_RENDER_FLAGS, 3'($urandom_range(0, 7)),
                                    8'($urandom_range(0, 255)));
        rq.zero_hit_seen = zero_hit;
        rq.overflow_seen = overflow;
        push_req(rq);
    endtask

    // load the video address, now and then a control write between the halves
    task automatic set_address(input logic [13:0] a);
        logic [1:0] junk;
        junk = 2'($urandom_range(0, 3));
        if (trk_toggle) rd(REG_STATUS);
        wr(REG_ADDR, {junk, a[13:8]});
        if ($urandom_range(0, 4) == 0) wr(REG_CTRL, 8'($urandom_range(0, 255)));
        wr(REG_ADDR, a[7:0]);
    endtask

    // often a small pattern window so that reads land on written bytes
    function automatic logic [13:0] pick_address();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4) return 14'($urandom_range(0, 'h7F));
        if (k == 4) return 14'($urandom_range(0, 'h1FFF));
        if (k < 8) return 14'($urandom_range('h2000, 'h3EFF));
        return 14'($urandom_range('h3F00, 'h3FFF));
    endfunction

    // mirroring changes only with nothing outstanding
    task automatic write_mirror(input logic v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_burst();
        int         kind;
        int         n;
        logic [7:0] spr;
        kind = $urandom_range(0, 99);
        n    = $urandom_range(1, 8);
        spr  = 8'($urandom_range(0, 255));
        if (kind < 25) begin
            // video memory fill
            if ($urandom_range(0, 1)) wr(REG_CTRL, 8'($urandom_range(0, 255)));
            set_address(pick_address());
            repeat (n) wr(REG_DATA, 8'($urandom_range(0, 255)));
        end else if (kind < 50) begin
            // buffered read-back
            set_address(pick_address());
            repeat (n) rd(REG_DATA);
        end else if (kind < 62) begin
            // sprite bytes written and read back
            wr(REG_OAM_ADDR, spr);
            repeat (n) wr(REG_OAM_DATA, 8'($urandom_range(0, 255)));
            wr(REG_OAM_ADDR, spr);
            repeat (n) rd(REG_OAM_DATA);
        end else if (kind < 72) begin
            if ($urandom_range(0, 3) == 0) rd(REG_STATUS);
            wr(REG_SCROLL, 8'($urandom_range(0, 255)));
            wr(REG_SCROLL, 8'($urandom_range(0, 255)));
        end else if (kind < 82) begin
            // frame events and status polling
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 3))
                    0: frame_event(MODE_VBLANK_START);
                    1: frame_event(MODE_PRERENDER_CLEAR);
                    2: render_flags(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    default: rd(REG_STATUS);
                endcase
            end
        end else if (kind < 90) begin
            wr($urandom_range(0, 1) ? REG_MASK : REG_CTRL, 8'($urandom_range(0, 255)));
        end else begin
            // noise
            repeat ($urandom_range(1, 3))
                push_req(make_req(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                  8'($urandom_range(0, 255))));
        end
    endtask

    initial begin
        int goal;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        write_mirror(1'b0);

        // directed: status flags, nmi, sprite wrap, palette fold and grayscale
        rd(REG_STATUS);
        wr(REG_CTRL, 8'h80);
        frame_event(MODE_VBLANK_START);
        rd(REG_STATUS);
        render_flags(1'b1, 1'b1);
        render_flags(1'b0, 1'b0);
        rd(REG_STATUS);
        frame_event(MODE_PRERENDER_CLEAR);
        wr(REG_OAM_ADDR, 8'hFF);
        wr(REG_OAM_DATA, 8'hA5);
        wr(REG_OAM_ADDR, 8'hFF);
        rd(REG_OAM_DATA);
        wr(REG_SCROLL, 8'hFF);
        wr(REG_SCROLL, 8'h00);
        wr(REG_ADDR, 8'h3F);
        wr(REG_ADDR, 8'h10);
        wr(REG_DATA, 8'hFF);
        wr(REG_MASK, 8'h01);
        wr(REG_ADDR, 8'h3F);
        wr(REG_ADDR, 8'h00);
        rd(REG_DATA);
        // step of 32 across the top of the 14-bit space
        wr(REG_CTRL, 8'h07);
        wr(REG_ADDR, 8'h7F);
        wr(REG_ADDR, 8'hFF);
        wr(REG_DATA, 8'h00);
        // unused modes and registers
        frame_event(MODE_UNUSED_LO);
        frame_event(MODE_UNUSED_HI);
        rd(REG_CTRL);
        wr(REG_STATUS, 8'h55);

        goal = items_sent;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_mirror(ph % 2 == 0);
            if (ph == 1) squeeze_go <= 1'b1;
            quiet <= (ph == 2);
            goal += RANDOM_ITEMS / PHASES;
            while (items_sent < goal) random_burst();
        end

        // drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
sv/vrp_pkg.sv
sv/vrp_ram.sv
sv/vrp_ctrl.sv
sv/vrp_dp.sv
sv/video_register_port_with_vram_map.sv
tb/sv/vrp_port_checker.sv
tb/sv/tb.sv
